### sv/lsre_pkg.sv
// package: constants, types and colour helpers for the led strip rainbow effect unit
`default_nettype none
package lsre_pkg;

  parameter int LedMax   = 64;
  parameter int IdxW     = 6;
  parameter int CntW     = 7;
  parameter int CfgIdxW  = 2;
  parameter int CfgDataW = 7;

  parameter logic [CfgIdxW-1:0] CfgEffectMode = 2'd0;
  parameter logic [CfgIdxW-1:0] CfgReverse    = 2'd1;
  parameter logic [CfgIdxW-1:0] CfgLedCount   = 2'd2;

  parameter logic [1:0] EffOff     = 2'd0;
  parameter logic [1:0] EffRainbow = 2'd1;
  parameter logic [1:0] EffChase   = 2'd2;

  parameter logic [CntW-1:0] LedCountReset = 7'd60;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // colour wheel over red, green and blue thirds
  function automatic rgb_t wheel(input logic [7:0] w);
    rgb_t       c;
    logic [6:0] v;
    logic [8:0] t3;
    logic [7:0] up;
    logic [7:0] dn;
    if (w < 8'd85) begin
      v = w[6:0];
    end else if (w < 8'd170) begin
      v = 7'(w - 8'd85);
    end else begin
      v = 7'(w - 8'd170);
    end
    t3 = {1'b0, v, 1'b0} + {2'b00, v};
    up = t3[7:0];
    dn = 8'd255 - up;
    if (w < 8'd85) begin
      c.red   = up;
      c.green = dn;
      c.blue  = 8'd0;
    end else if (w < 8'd170) begin
      c.red   = dn;
      c.green = 8'd0;
      c.blue  = up;
    end else begin
      c.red   = 8'd0;
      c.green = up;
      c.blue  = dn;
    end
    return c;
  endfunction

  // residue modulo three from base-four digit sums
  function automatic logic [1:0] mod3(input logic [IdxW-1:0] x);
    logic [3:0] s;
    logic [2:0] t;
    s = {2'b00, x[5:4]} + {2'b00, x[3:2]} + {2'b00, x[1:0]};
    t = {1'b0, s[3:2]} + {1'b0, s[1:0]};
    if (t >= 3'd3) begin
      t = t - 3'd3;
    end
    return t[1:0];
  endfunction

  // chase wheel position, (k - offset + phase) modulo 255
  function automatic logic [7:0] chase_pos(input logic [IdxW-1:0] k, input logic [1:0] ofs,
                                           input logic [7:0] ph);
    logic [8:0] s;
    s = {3'b000, k} - {7'd0, ofs} + {1'b0, ph};
    if (s >= 9'd255) begin
      s = s - 9'd255;
    end
    return s[7:0];
  endfunction

endpackage
`default_nettype wire

### sv/lsre_cfg_if.sv
// interface: configuration write channel
`default_nettype none
interface lsre_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [lsre_pkg::CfgIdxW-1:0]      index;
  logic [lsre_pkg::CfgDataW-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### sv/lsre_tick_if.sv
// interface: frame tick input channel
`default_nettype none
interface lsre_tick_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface
`default_nettype wire

### sv/lsre_pixel_if.sv
// interface: pixel colour output channel
`default_nettype none
interface lsre_pixel_if;
  logic                         valid;
  logic                         ready;
  logic [lsre_pkg::IdxW-1:0]    pixel_index;
  logic [7:0]                   red;
  logic [7:0]                   green;
  logic [7:0]                   blue;
  logic                         last;

  modport source (output valid, output pixel_index, output red, output green, output blue,
                  output last, input ready);
  modport sink   (input valid, input pixel_index, input red, input green, input blue,
                  input last, output ready);
endinterface
`default_nettype wire

### sv/led_strip_rainbow_effect_unit.sv
// top level: led strip rainbow and theater chase colour generator
//
//   port   dir   transaction
//   cfg    in    register write: index, data
//   tick   in    one frame tick: restart
//   pixel  out   one led colour: pixel_index, red, green, blue, last
//
// a tick yields min(led_count, 64) pixel transactions, then ready returns
// rainbow: each pixel passes load, the 8-step shift-subtract divider, then show
// chase, off and the unused code: each pixel passes load, then show; each tick also passes idle
// synchronous reset restores the config registers to their defaults and clears the phase and chase offset
// a stalled pixel holds its colour; config is taken at any cycle
`default_nettype none
module led_strip_rainbow_effect_unit (
  input  wire             clk,
  input  wire             rst,
  lsre_cfg_if.sink        cfg,
  lsre_tick_if.sink       tick,
  lsre_pixel_if.source    pixel
);

  typedef enum logic [1:0] {ST_IDLE, ST_PIXEL, ST_DIV, ST_SHOW} state_t;

  state_t                          state;
  logic [1:0]                      effect_mode;
  logic                            reverse;
  logic [lsre_pkg::CntW-1:0]       led_count;
  logic [7:0]                      phase;
  logic [1:0]                      chase_offset;

  logic [7:0]                      fr_phase;
  logic [1:0]                      fr_chase;
  logic [lsre_pkg::CntW-1:0]       n;
  logic [lsre_pkg::IdxW-1:0]       p;
  logic [lsre_pkg::CntW-1:0]       rem;
  logic [7:0]                      q;
  logic [2:0]                      step;

  logic [lsre_pkg::IdxW-1:0]       pix_idx;
  lsre_pkg::rgb_t                  pix_rgb;
  logic                            pix_last;

  logic [lsre_pkg::CntW-1:0]       n_eff;
  logic [7:0]                      ph_start;
  logic [1:0]                      ch_start;
  logic [lsre_pkg::IdxW-1:0]       pos_rev;
  logic [lsre_pkg::IdxW-1:0]       pos_rb;
  logic [lsre_pkg::IdxW-1:0]       pos_ch;
  logic                            p_last;
  logic                            lit;
  lsre_pkg::rgb_t                  chase_rgb;
  logic [7:0]                      trial;
  logic                            ge;
  logic [lsre_pkg::CntW-1:0]       rem_next;
  logic [7:0]                      q_fin;
  lsre_pkg::rgb_t                  rainbow_rgb;

  assign cfg.ready         = 1'b1;
  assign tick.ready        = (state == ST_IDLE);
  assign pixel.valid       = (state == ST_SHOW);
  assign pixel.pixel_index = pix_idx;
  assign pixel.red         = pix_rgb.red;
  assign pixel.green       = pix_rgb.green;
  assign pixel.blue        = pix_rgb.blue;
  assign pixel.last        = pix_last;

  always_comb begin
    n_eff    = (led_count > lsre_pkg::CntW'(lsre_pkg::LedMax)) ?
               lsre_pkg::CntW'(lsre_pkg::LedMax) : led_count;
    ph_start = tick.restart ? 8'd0 : phase;
    ch_start = tick.restart ? 2'd0 : chase_offset;
    pos_rev  = lsre_pkg::IdxW'(n - 7'd1 - {1'b0, p});
    pos_rb   = reverse ? pos_rev : p;
    pos_ch   = reverse ? p : pos_rev;
    p_last   = ({1'b0, p} == (n - 7'd1));
    lit      = (lsre_pkg::mod3(pos_ch) == fr_chase);
    chase_rgb = lit ? lsre_pkg::wheel(lsre_pkg::chase_pos(pos_ch, fr_chase, fr_phase)) : '0;
    trial    = {rem, 1'b0};
    ge       = (trial >= {1'b0, n});
    rem_next = ge ? lsre_pkg::CntW'(trial - {1'b0, n}) : lsre_pkg::CntW'(trial);
    q_fin    = {q[6:0], ge};
    rainbow_rgb = lsre_pkg::wheel(q_fin + fr_phase);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      effect_mode  <= lsre_pkg::EffOff;
      reverse      <= 1'b0;
      led_count    <= lsre_pkg::LedCountReset;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        lsre_pkg::CfgEffectMode: effect_mode <= cfg.data[1:0];
        lsre_pkg::CfgReverse:    reverse     <= cfg.data[0];
        lsre_pkg::CfgLedCount:   led_count   <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      phase        <= 8'd0;
      chase_offset <= 2'd0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (tick.valid) begin
            fr_phase <= ph_start;
            fr_chase <= ch_start;
            n        <= n_eff;
            p        <= '0;
            phase        <= ph_start;
            chase_offset <= ch_start;
            if (effect_mode == lsre_pkg::EffRainbow) begin
              phase <= ph_start + 8'd1;
            end else if (effect_mode == lsre_pkg::EffChase) begin
              if (ch_start == 2'd2) begin
                chase_offset <= 2'd0;
                phase        <= ph_start + 8'd1;
              end else begin
                chase_offset <= ch_start + 2'd1;
              end
            end
            if (n_eff != '0) begin
              state <= ST_PIXEL;
            end
          end
        end
        ST_PIXEL: begin
          pix_idx  <= p;
          pix_last <= p_last;
          if (effect_mode == lsre_pkg::EffRainbow) begin
            rem   <= {1'b0, pos_rb};
            q     <= '0;
            step  <= '0;
            state <= ST_DIV;
          end else begin
            pix_rgb <= (effect_mode == lsre_pkg::EffChase) ? chase_rgb : '0;
            state   <= ST_SHOW;
          end
        end
        ST_DIV: begin
          rem  <= rem_next;
          q    <= q_fin;
          step <= step + 3'd1;
          if (step == 3'd7) begin
            pix_rgb <= rainbow_rgb;
            state   <= ST_SHOW;
          end
        end
        ST_SHOW: begin
          if (pixel.ready) begin
            if (pix_last) begin
              state <= ST_IDLE;
            end else begin
              p     <= p + 6'd1;
              state <= ST_PIXEL;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_idle_no_pixel: assert property (@(posedge clk) disable iff (rst)
    tick.ready |-> !pixel.valid)
    else $error("pixel offered while idle");

  a_last_at_end: assert property (@(posedge clk) disable iff (rst)
    pixel.valid && pixel.last |-> ({1'b0, pixel.pixel_index} == (n - 7'd1)))
    else $error("last flag on wrong pixel");

  a_frame_goes_on: assert property (@(posedge clk) disable iff (rst)
    pixel.valid && pixel.ready && !pixel.last |=> !tick.ready)
    else $error("frame ended before last pixel");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> rem < n)
    else $error("divider remainder out of range");

  a_chase_range: assert property (@(posedge clk) disable iff (rst)
    chase_offset != 2'd3)
    else $error("chase offset out of range");

endmodule
`default_nettype wire

### sim/tb_led_strip_rainbow_effect_unit.sv
// testbench: led strip rainbow effect unit, every pixel checked against a frame colour predictor
module tb_led_strip_rainbow_effect_unit;

  localparam logic [lsre_pkg::CfgIdxW-1:0] CfgSpare = 2'd3;
  localparam logic [1:0] EffSpare = 2'd3;
  localparam int QuietLimit = 2000;

  typedef struct packed {
    logic [lsre_pkg::IdxW-1:0] index;
    lsre_pkg::rgb_t            colour;
    logic                      last;
  } led_colour_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lsre_cfg_if   cfg_ch ();
  lsre_tick_if  tick_ch ();
  lsre_pixel_if pixel_ch ();

  led_strip_rainbow_effect_unit uut (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg_ch),
    .tick  (tick_ch),
    .pixel (pixel_ch)
  );

  // predictor state, mirrors the block registers and animation
  logic [1:0]                eff_mode;
  logic                      rev_order;
  logic [lsre_pkg::CntW-1:0] strip_len;
  logic [7:0]                hue_phase;
  logic [1:0]                chase_ofs;

  led_colour_t colours_due[$];
  logic        restart_q[$];
  int          ticks_queued = 0;
  int          ticks_taken  = 0;
  int          mismatches   = 0;
  int          quiet        = 0;
  logic        src_idle     = 1'b1;
  logic        snk_idle     = 1'b1;
  int          tick_gap     = 0;
  int          snk_stall    = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic lsre_pkg::rgb_t hue_to_rgb(input int unsigned pos);
    lsre_pkg::rgb_t c;
    int unsigned    w;
    w = pos % 256;
    if (w < 85) begin
      c.red   = 8'(3 * w);
      c.green = 8'(255 - 3 * w);
      c.blue  = 8'd0;
    end else if (w < 170) begin
      w = w - 85;
      c.red   = 8'(255 - 3 * w);
      c.green = 8'd0;
      c.blue  = 8'(3 * w);
    end else begin
      w = w - 170;
      c.red   = 8'd0;
      c.green = 8'(3 * w);
      c.blue  = 8'(255 - 3 * w);
    end
    return c;
  endfunction

  task automatic paint_frame(input logic restart);
    int unsigned n;
    int unsigned p;
    int unsigned k;
    led_colour_t e;
    n = (strip_len > lsre_pkg::LedMax) ? lsre_pkg::LedMax : strip_len;
    if (restart) begin
      hue_phase = 8'd0;
      chase_ofs = 2'd0;
    end
    for (p = 0; p < n; p++) begin
      e.index  = lsre_pkg::IdxW'(p);
      e.colour = '0;
      e.last   = (p + 1 == n);
      if (eff_mode == lsre_pkg::EffRainbow) begin
        k = rev_order ? n - 1 - p : p;
        e.colour = hue_to_rgb((k * 256 / n + hue_phase) % 256);
      end else if (eff_mode == lsre_pkg::EffChase) begin
        k = rev_order ? p : n - 1 - p;
        if (k % 3 == chase_ofs) e.colour = hue_to_rgb((k - chase_ofs + hue_phase) % 255);
      end
      colours_due.push_back(e);
    end
    if (eff_mode == lsre_pkg::EffRainbow) begin
      hue_phase = hue_phase + 8'd1;
    end else if (eff_mode == lsre_pkg::EffChase) begin
      if (chase_ofs == 2'd2) begin
        chase_ofs = 2'd0;
        hue_phase = hue_phase + 8'd1;
      end else begin
        chase_ofs = chase_ofs + 2'd1;
      end
    end
  endtask

  task automatic note_error(input string what, input led_colour_t want, input led_colour_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%s: expected %0d rgb %h%h%h last %0b, got %0d rgb %h%h%h last %0b",
               what, want.index, want.colour.red, want.colour.green, want.colour.blue, want.last,
               got.index, got.colour.red, got.colour.green, got.colour.blue, got.last);
  endtask

  // tick driver
  always @(posedge clk) begin
    int gap;
    if (rst) begin
      tick_ch.valid   <= 1'b0;
      tick_ch.restart <= 1'b0;
      tick_gap        <= 0;
    end else if (tick_ch.valid && tick_ch.ready) begin
      gap = src_idle ? $urandom_range(0, 10) : 0;
      if (gap == 0 && restart_q.size() > 0) begin
        tick_ch.restart <= restart_q.pop_front();
      end else begin
        tick_ch.valid <= 1'b0;
        tick_gap      <= gap;
      end
    end else if (!tick_ch.valid) begin
      if (tick_gap > 0) begin
        tick_gap <= tick_gap - 1;
      end else if (restart_q.size() > 0) begin
        tick_ch.valid   <= 1'b1;
        tick_ch.restart <= restart_q.pop_front();
      end
    end
  end

  // pixel sink back-pressure
  always @(posedge clk) begin
    int stall;
    if (rst) begin
      pixel_ch.ready <= 1'b0;
      snk_stall      <= 0;
    end else if (pixel_ch.valid && pixel_ch.ready) begin
      stall = snk_idle ? $urandom_range(0, 10) : 0;
      if (stall != 0) begin
        pixel_ch.ready <= 1'b0;
        snk_stall      <= stall;
      end
    end else if (snk_stall > 0) begin
      snk_stall <= snk_stall - 1;
    end else begin
      pixel_ch.ready <= 1'b1;
    end
  end

  // monitor: register writes, frame prediction, pixel checks
  always @(posedge clk) begin
    led_colour_t got;
    led_colour_t want;
    if (rst) begin
      eff_mode  = lsre_pkg::EffOff;
      rev_order = 1'b0;
      strip_len = lsre_pkg::LedCountReset;
      hue_phase = 8'd0;
      chase_ofs = 2'd0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          lsre_pkg::CfgEffectMode: eff_mode  = cfg_ch.data[1:0];
          lsre_pkg::CfgReverse:    rev_order = cfg_ch.data[0];
          lsre_pkg::CfgLedCount:   strip_len = cfg_ch.data[lsre_pkg::CntW-1:0];
          default: ;
        endcase
      end
      if (tick_ch.valid && tick_ch.ready) begin
        paint_frame(tick_ch.restart);
        ticks_taken++;
      end
      if (pixel_ch.valid && pixel_ch.ready) begin
        got.index  = pixel_ch.pixel_index;
        got.colour = {pixel_ch.red, pixel_ch.green, pixel_ch.blue};
        got.last   = pixel_ch.last;
        if (colours_due.size() == 0) begin
          note_error("unexpected pixel", '0, got);
        end else begin
          want = colours_due.pop_front();
          if (got !== want) note_error("pixel mismatch", want, got);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (cfg_ch.valid && cfg_ch.ready) || (tick_ch.valid && tick_ch.ready)
        || (pixel_ch.valid && pixel_ch.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == QuietLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic drain();
    while (ticks_taken != ticks_queued || colours_due.size() != 0) @(posedge clk);
    while (tick_ch.ready !== 1'b1) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic put_reg(input logic [lsre_pkg::CfgIdxW-1:0] idx,
                         input logic [lsre_pkg::CfgDataW-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
  endtask

  task automatic setup(input logic [1:0] mode, input logic rev,
                       input logic [lsre_pkg::CntW-1:0] len);
    drain();
    src_idle <= ($urandom_range(0, 3) != 0);
    snk_idle <= ($urandom_range(0, 3) != 0);
    if ($urandom_range(0, 2) == 0) put_reg(CfgSpare, lsre_pkg::CfgDataW'($urandom));
    put_reg(lsre_pkg::CfgEffectMode, {5'($urandom), mode});
    put_reg(lsre_pkg::CfgReverse, {6'($urandom), rev});
    put_reg(lsre_pkg::CfgLedCount, len);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send(input logic rs);
    restart_q.push_back(rs);
    ticks_queued++;
  endtask

  function automatic logic [lsre_pkg::CntW-1:0] pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 75) return lsre_pkg::CntW'($urandom_range(1, 16));
    if (r < 90) return lsre_pkg::CntW'($urandom_range(17, 63));
    if (r < 96) return lsre_pkg::CntW'(lsre_pkg::LedMax);
    return lsre_pkg::CntW'($urandom_range(65, 127));
  endfunction

  initial begin
    logic [1:0] mode;
    int         r;
    int         burst;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= lsre_pkg::CfgEffectMode;
    cfg_ch.data     <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // defaults after reset
    send(1'b0);
    setup(lsre_pkg::EffRainbow, 1'b0, lsre_pkg::CntW'(lsre_pkg::LedMax));
    send(1'b1);
    send(1'b0);
    setup(lsre_pkg::EffRainbow, 1'b1, 7'd7);
    send(1'b0);
    send(1'b0);
    setup(lsre_pkg::EffChase, 1'b0, 7'd10);
    repeat (4) send(1'b0);
    setup(lsre_pkg::EffChase, 1'b1, lsre_pkg::CntW'(lsre_pkg::LedMax));
    send(1'b0);
    send(1'b1);
    // unused effect code and oversize count
    setup(EffSpare, 1'b1, 7'd127);
    send(1'b0);
    // empty strip still advances the chase
    setup(lsre_pkg::EffChase, 1'b0, 7'd0);
    repeat (3) send(1'b0);
    setup(lsre_pkg::EffChase, 1'b0, 7'd5);
    send(1'b0);
    // effect change without restart
    setup(lsre_pkg::EffRainbow, 1'b0, 7'd1);
    send(1'b0);
    send(1'b1);

    // long run on a tiny strip to advance the phase over many frames
    setup(lsre_pkg::EffRainbow, 1'($urandom), lsre_pkg::CntW'($urandom_range(1, 2)));
    repeat (180) send(1'b0);

    while (ticks_queued < 300) begin
      r = $urandom_range(0, 9);
      mode = (r == 0) ? lsre_pkg::EffOff : (r < 5) ? lsre_pkg::EffRainbow :
             (r < 9) ? lsre_pkg::EffChase : EffSpare;
      setup(mode, 1'($urandom), pick_len());
      burst = $urandom_range(3, 15);
      repeat (burst) send($urandom_range(0, 47) == 0);
    end

    setup(lsre_pkg::EffOff, 1'b0, lsre_pkg::LedCountReset);
    send(1'b1);
    drain();
    repeat (30) @(posedge clk);
    if (mismatches == 0 && colours_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
